### src/crs_pkg.sv
// Shared constants for the Catmull-Rom spline evaluator.
// Holds default sizes, operand widths, item kinds, status codes and register indexes.
// Depends on nothing; the top level and the bench import it.
`default_nettype none

package crs_pkg;

    parameter int DEF_MAX_POINTS  = 16;
    parameter int DEF_COORD_WIDTH = 32;

    parameter int FRAC_W    = 16;
    parameter int FRAC_ONE  = 65536;
    parameter int HALF_Q16  = 32768;
    parameter int COEF_W    = 19;
    parameter int PARAM_W   = 24;
    parameter int COUNT_W   = 5;
    parameter int DATA_W    = 32;

    parameter logic KIND_WRITE = 1'b0;
    parameter logic KIND_EVAL  = 1'b1;

    parameter logic [1:0] ST_SPLINE = 2'd0;
    parameter logic [1:0] ST_SINGLE = 2'd1;
    parameter logic [1:0] ST_EMPTY  = 2'd2;

    parameter logic REG_POINT_COUNT = 1'b0;

endpackage

`default_nettype wire

### src/crs_point_mem.sv
// Control point storage for the spline evaluator: one write port, one registered read port.
// Each word holds the x coordinate above the y coordinate.
// Depends on no package.
`default_nettype none

module crs_point_mem #(
    parameter int DEPTH  = 16,
    parameter int WORD_W = 64
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [WORD_W-1:0]          wr_data,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic      [WORD_W-1:0]          rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### src/crs_mul.sv
// Shared signed multiplier of the spline evaluator with a registered product.
// Every product of the evaluation passes through this one unit.
// Depends on no package.
`default_nettype none

module crs_mul #(
    parameter int A_W = 19,
    parameter int B_W = 33
) (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic signed [A_W-1:0]       a,
    input  wire logic signed [B_W-1:0]       b,
    output logic      signed [A_W+B_W-1:0]   prod
);

    logic signed [A_W+B_W-1:0] prod_reg;
    logic signed [A_W+B_W-1:0] prod_next;

    assign prod_next = (A_W+B_W)'(a) * (A_W+B_W)'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

### src/catmull_rom_spline_eval.sv
// Top level of the uniform Catmull-Rom spline evaluator over a table of 2D control points.
// Holds the sequencer, the APB register, the blending datapath and the result register.
// Depends on crs_pkg, crs_point_mem and crs_mul.
`default_nettype none

// A write beat stores one control point. An evaluate beat with two or more points goes from
// acceptance to a registered result via a setup step that clamps the parameter, fourteen
// steps in which four table reads overlap ten products on the one shared multiplier (two for
// the basis, four per axis), and a final step that rounds, saturates and waits for a free
// output slot. item_stall is high for that whole time. A finished result waits in the output
// register, and the block takes further write beats and starts the next evaluation meanwhile.
module catmull_rom_spline_eval #(
    parameter int MAX_POINTS  = crs_pkg::DEF_MAX_POINTS,
    parameter int COORD_WIDTH = crs_pkg::DEF_COORD_WIDTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [2:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic      [31:0]    prdata,
    output logic                pready,
    input  wire logic           item_valid,
    output logic                item_stall,
    input  wire logic           kind,
    input  wire logic [3:0]     point_index,
    input  wire logic [31:0]    point_x,
    input  wire logic [31:0]    point_y,
    input  wire logic [23:0]    param,
    output logic                result_valid,
    input  wire logic           result_stall,
    output logic      [31:0]    out_x,
    output logic      [31:0]    out_y,
    output logic      [1:0]     status
);

    import crs_pkg::*;

    localparam int CW     = (COORD_WIDTH < DATA_W) ? COORD_WIDTH : DATA_W;
    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int MA_W   = COEF_W;
    localparam int MB_W   = (CW + 1 > FRAC_W + 2) ? CW + 1 : FRAC_W + 2;
    localparam int P_W    = MA_W + MB_W;
    localparam int ACC_W  = P_W + 2;
    localparam int H_W    = COEF_W + 3;

    localparam logic [3:0] STEP_LAST = 4'd13;

    localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SETUP  = 5'b00010,
        ST_POINT0 = 5'b00100,
        ST_CALC   = 5'b01000,
        ST_FIN    = 5'b10000
    } state_t;

    state_t                      state_reg, state_next;
    logic [3:0]                  step_reg, step_next;
    logic [COUNT_W-1:0]          point_count_reg, point_count_next;
    logic [COUNT_W-1:0]          cnt_reg, cnt_next;
    logic [PARAM_W-1:0]          param_reg, param_next;
    logic [COUNT_W-1:0]          s_reg, s_next;
    logic [FRAC_W:0]             t_reg, t_next;
    logic                        first_reg, first_next;
    logic                        last_reg, last_next;
    logic [FRAC_W:0]             t2_reg, t2_next;
    logic [FRAC_W:0]             t3_reg, t3_next;
    logic signed [MA_W-1:0]      h00_reg, h00_next;
    logic signed [MA_W-1:0]      h01_reg, h01_next;
    logic signed [MA_W-1:0]      h10_reg, h10_next;
    logic signed [MA_W-1:0]      h11_reg, h11_next;
    logic signed [CW-1:0]        p0x_reg, p0x_next, p0y_reg, p0y_next;
    logic signed [CW-1:0]        p1x_reg, p1x_next, p1y_reg, p1y_next;
    logic signed [CW-1:0]        pmx_reg, pmx_next, pmy_reg, pmy_next;
    logic signed [CW-1:0]        ppx_reg, ppx_next, ppy_reg, ppy_next;
    logic signed [CW:0]          d0x_reg, d0x_next, d0y_reg, d0y_next;
    logic signed [CW:0]          d1x_reg, d1x_next, d1y_reg, d1y_next;
    logic signed [ACC_W-1:0]     accx_reg, accx_next, accy_reg, accy_next;
    logic [31:0]                 out_x_reg, out_x_next;
    logic [31:0]                 out_y_reg, out_y_next;
    logic [1:0]                  status_reg, status_next;
    logic                        result_valid_reg, result_valid_next;

    logic                        slot_free;
    logic                        item_take;
    logic                        mem_wr_en;
    logic [IDX_W-1:0]            mem_rd_addr;
    logic [2*CW-1:0]             mem_rd_data;
    logic signed [CW-1:0]        rd_x, rd_y;
    logic                        mul_en;
    logic signed [MA_W-1:0]      mul_a;
    logic signed [MB_W-1:0]      mul_b;
    logic signed [P_W-1:0]       mul_prod;
    logic signed [P_W-1:0]       prod_rnd;
    logic signed [ACC_W-1:0]     prod_ext;

    logic [COUNT_W-1:0]          cnt_clamp;
    logic [COUNT_W-1:0]          cnt_m1;
    logic [PARAM_W-1:0]          lim_w;
    logic [PARAM_W-1:0]          param_c;
    logic [7:0]                  s_raw;
    logic [COUNT_W-1:0]          s_w;
    logic [PARAM_W-1:0]          t_w;
    logic [COUNT_W:0]            s_p1, s_p2;
    logic [COUNT_W-1:0]          s_m1;
    logic signed [H_W-1:0]       t_s, t2_s, t3_s;
    logic signed [H_W-1:0]       h00_w, h01_w, h10_w, h11_w;
    logic signed [CW-1:0]        res_x, res_y;

    function automatic logic signed [CW-1:0] sat_round(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] rounded;
        logic signed [ACC_W-1:0] shifted;
        logic signed [ACC_W-1:0] clipped;
        rounded = acc + ACC_W'(FRAC_ONE);
        shifted = rounded >>> (FRAC_W + 1);
        if (shifted > SAT_HI)
        begin
            clipped = SAT_HI;
        end
        else if (shifted < SAT_LO)
        begin
            clipped = SAT_LO;
        end
        else
        begin
            clipped = shifted;
        end
        return clipped[CW-1:0];
    endfunction

    crs_point_mem #(
        .DEPTH  (MAX_POINTS),
        .WORD_W (2*CW)
    ) u_point_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (IDX_W'(point_index)),
        .wr_data ({point_x[CW-1:0], point_y[CW-1:0]}),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    crs_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_POINT_COUNT) ? 32'(point_count_reg) : '0;
    assign item_stall = (state_reg != ST_IDLE);
    assign item_take  = item_valid && !item_stall;
    assign slot_free  = !result_valid_reg || !result_stall;
    assign mem_wr_en  = item_take && (kind == KIND_WRITE) && (32'(point_index) < MAX_POINTS);

    assign rd_x = $signed(mem_rd_data[2*CW-1:CW]);
    assign rd_y = $signed(mem_rd_data[CW-1:0]);

    assign cnt_clamp = (32'(point_count_reg) > MAX_POINTS) ? COUNT_W'(MAX_POINTS)
                                                           : point_count_reg;
    assign cnt_m1  = cnt_reg - COUNT_W'(1);
    assign lim_w   = {3'b000, cnt_m1, 16'h0000};
    assign param_c = (param_reg > lim_w) ? lim_w : param_reg;
    assign s_raw   = param_c[PARAM_W-1:FRAC_W];
    assign s_w     = (s_raw >= {3'b000, cnt_m1}) ? (cnt_reg - COUNT_W'(2)) : s_raw[COUNT_W-1:0];
    assign t_w     = param_c - {3'b000, s_w, 16'h0000};

    assign s_p1 = {1'b0, s_reg} + (COUNT_W+1)'(1);
    assign s_p2 = {1'b0, s_reg} + (COUNT_W+1)'(2);
    assign s_m1 = s_reg - COUNT_W'(1);

    assign prod_rnd = mul_prod + P_W'(HALF_Q16);
    assign prod_ext = ACC_W'(mul_prod);

    assign t_s  = $signed(H_W'(t_reg));
    assign t2_s = $signed(H_W'(t2_reg));
    assign t3_s = $signed(H_W'(t3_reg));
    assign h00_w = (t3_s <<< 2) - (t2_s <<< 2) - (t2_s <<< 1) + H_W'(2 * FRAC_ONE);
    assign h01_w = (t2_s <<< 2) + (t2_s <<< 1) - (t3_s <<< 2);
    assign h10_w = t3_s - (t2_s <<< 1) + t_s;
    assign h11_w = t3_s - t2_s;

    assign res_x = sat_round(accx_reg);
    assign res_y = sat_round(accy_reg);

    always_comb
    begin
        mem_rd_addr = '0;
        mul_en      = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        if (state_reg == ST_CALC)
        begin
            case (step_reg)
                4'd0:
                begin
                    mem_rd_addr = IDX_W'(s_reg);
                    mul_en      = 1'b1;
                    mul_a       = MA_W'(t_reg);
                    mul_b       = MB_W'(t_reg);
                end
                4'd1:
                begin
                    mem_rd_addr = IDX_W'(s_p1);
                end
                4'd2:
                begin
                    mem_rd_addr = first_reg ? IDX_W'(s_reg) : IDX_W'(s_m1);
                    mul_en      = 1'b1;
                    mul_a       = MA_W'(t2_reg);
                    mul_b       = MB_W'(t_reg);
                end
                4'd3:
                begin
                    mem_rd_addr = last_reg ? IDX_W'(s_reg) : IDX_W'(s_p2);
                end
                4'd5:
                begin
                    mul_en = 1'b1;
                    mul_a  = h00_reg;
                    mul_b  = MB_W'(p0x_reg);
                end
                4'd6:
                begin
                    mul_en = 1'b1;
                    mul_a  = h00_reg;
                    mul_b  = MB_W'(p0y_reg);
                end
                4'd7:
                begin
                    mul_en = 1'b1;
                    mul_a  = h01_reg;
                    mul_b  = MB_W'(p1x_reg);
                end
                4'd8:
                begin
                    mul_en = 1'b1;
                    mul_a  = h01_reg;
                    mul_b  = MB_W'(p1y_reg);
                end
                4'd9:
                begin
                    mul_en = 1'b1;
                    mul_a  = h10_reg;
                    mul_b  = MB_W'(d0x_reg);
                end
                4'd10:
                begin
                    mul_en = 1'b1;
                    mul_a  = h10_reg;
                    mul_b  = MB_W'(d0y_reg);
                end
                4'd11:
                begin
                    mul_en = 1'b1;
                    mul_a  = h11_reg;
                    mul_b  = MB_W'(d1x_reg);
                end
                4'd12:
                begin
                    mul_en = 1'b1;
                    mul_a  = h11_reg;
                    mul_b  = MB_W'(d1y_reg);
                end
                default:
                begin
                    mul_en = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        point_count_next  = point_count_reg;
        cnt_next          = cnt_reg;
        param_next        = param_reg;
        s_next            = s_reg;
        t_next            = t_reg;
        first_next        = first_reg;
        last_next         = last_reg;
        t2_next           = t2_reg;
        t3_next           = t3_reg;
        h00_next          = h00_reg;
        h01_next          = h01_reg;
        h10_next          = h10_reg;
        h11_next          = h11_reg;
        p0x_next          = p0x_reg;
        p0y_next          = p0y_reg;
        p1x_next          = p1x_reg;
        p1y_next          = p1y_reg;
        pmx_next          = pmx_reg;
        pmy_next          = pmy_reg;
        ppx_next          = ppx_reg;
        ppy_next          = ppy_reg;
        d0x_next          = d0x_reg;
        d0y_next          = d0y_reg;
        d1x_next          = d1x_reg;
        d1y_next          = d1y_reg;
        accx_next         = accx_reg;
        accy_next         = accy_reg;
        out_x_next        = out_x_reg;
        out_y_next        = out_y_reg;
        status_next       = status_reg;
        result_valid_next = result_valid_reg && result_stall;

        if (psel && penable && pwrite && (paddr[2] == REG_POINT_COUNT))
        begin
            point_count_next = pwdata[COUNT_W-1:0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_take && (kind == KIND_EVAL))
                begin
                    param_next = param;
                    cnt_next   = cnt_clamp;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (cnt_reg == '0)
                begin
                    if (slot_free)
                    begin
                        out_x_next        = '0;
                        out_y_next        = '0;
                        status_next       = ST_EMPTY;
                        result_valid_next = 1'b1;
                        state_next        = ST_IDLE;
                    end
                end
                else if (cnt_reg == COUNT_W'(1))
                begin
                    state_next = ST_POINT0;
                end
                else
                begin
                    s_next     = s_w;
                    t_next     = t_w[FRAC_W:0];
                    first_next = (s_w == '0);
                    last_next  = ({1'b0, s_w} + (COUNT_W+1)'(2)) >= {1'b0, cnt_reg};
                    step_next  = '0;
                    state_next = ST_CALC;
                end
            end
            ST_POINT0:
            begin
                if (slot_free)
                begin
                    out_x_next        = 32'(rd_x);
                    out_y_next        = 32'(rd_y);
                    status_next       = ST_SINGLE;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            ST_CALC:
            begin
                step_next = step_reg + 4'd1;
                case (step_reg)
                    4'd1:
                    begin
                        t2_next  = prod_rnd[2*FRAC_W:FRAC_W];
                        p0x_next = rd_x;
                        p0y_next = rd_y;
                    end
                    4'd2:
                    begin
                        p1x_next = rd_x;
                        p1y_next = rd_y;
                    end
                    4'd3:
                    begin
                        t3_next  = prod_rnd[2*FRAC_W:FRAC_W];
                        pmx_next = rd_x;
                        pmy_next = rd_y;
                    end
                    4'd4:
                    begin
                        ppx_next = rd_x;
                        ppy_next = rd_y;
                        h00_next = h00_w[MA_W-1:0];
                        h01_next = h01_w[MA_W-1:0];
                        h10_next = h10_w[MA_W-1:0];
                        h11_next = h11_w[MA_W-1:0];
                    end
                    4'd5:
                    begin
                        d0x_next = first_reg ? '0 : ((CW+1)'(p1x_reg) - (CW+1)'(pmx_reg));
                        d0y_next = first_reg ? '0 : ((CW+1)'(p1y_reg) - (CW+1)'(pmy_reg));
                        d1x_next = last_reg  ? '0 : ((CW+1)'(ppx_reg) - (CW+1)'(p0x_reg));
                        d1y_next = last_reg  ? '0 : ((CW+1)'(ppy_reg) - (CW+1)'(p0y_reg));
                    end
                    4'd6:
                    begin
                        accx_next = prod_ext;
                    end
                    4'd7:
                    begin
                        accy_next = prod_ext;
                    end
                    4'd8, 4'd10, 4'd12:
                    begin
                        accx_next = accx_reg + prod_ext;
                    end
                    4'd9, 4'd11, 4'd13:
                    begin
                        accy_next = accy_reg + prod_ext;
                    end
                    default:
                    begin
                        accx_next = accx_reg;
                    end
                endcase
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (slot_free)
                begin
                    out_x_next        = 32'(res_x);
                    out_y_next        = 32'(res_y);
                    status_next       = ST_SPLINE;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            point_count_reg  <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            point_count_reg  <= point_count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        param_reg  <= param_next;
        s_reg      <= s_next;
        t_reg      <= t_next;
        first_reg  <= first_next;
        last_reg   <= last_next;
        t2_reg     <= t2_next;
        t3_reg     <= t3_next;
        h00_reg    <= h00_next;
        h01_reg    <= h01_next;
        h10_reg    <= h10_next;
        h11_reg    <= h11_next;
        p0x_reg    <= p0x_next;
        p0y_reg    <= p0y_next;
        p1x_reg    <= p1x_next;
        p1y_reg    <= p1y_next;
        pmx_reg    <= pmx_next;
        pmy_reg    <= pmy_next;
        ppx_reg    <= ppx_next;
        ppy_reg    <= ppy_next;
        d0x_reg    <= d0x_next;
        d0y_reg    <= d0y_next;
        d1x_reg    <= d1x_next;
        d1y_reg    <= d1y_next;
        accx_reg   <= accx_next;
        accy_reg   <= accy_next;
        out_x_reg  <= out_x_next;
        out_y_reg  <= out_y_next;
        status_reg <= status_next;
    end

    assign result_valid = result_valid_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign status       = status_reg;

    a_eval_starts_setup: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (kind == KIND_EVAL) |=> state_reg == ST_SETUP)
        else $error("An accepted evaluate beat did not start the setup step.");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (kind == KIND_WRITE) |=> !$rose(result_valid_reg))
        else $error("A write beat produced a result.");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CALC |-> step_reg <= STEP_LAST)
        else $error("The step counter ran past the last blending step.");

    a_spline_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) && (status_reg == ST_SPLINE) |-> $past(state_reg == ST_FIN))
        else $error("A blended result appeared without the final rounding step.");

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking bench for catmull_rom_spline_eval: a directed table of beats, then random phases.
// Expected points come from a fixed-point spline predictor kept in step with each accepted beat.
// Depends on crs_pkg and the catmull_rom_spline_eval RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import crs_pkg::*;

    localparam int TABLE_SLOTS    = DEF_MAX_POINTS;
    localparam int RANDOM_BEATS   = 1700;
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [2:0] ADDR_POINT_COUNT = 3'(REG_POINT_COUNT) << 2;
    localparam logic [2:0] ADDR_UNMAPPED    = 3'((int'(REG_POINT_COUNT) + 1) * 4);

    localparam longint      COORD_MAX = 64'sd2147483647;
    localparam longint      COORD_MIN = -64'sd2147483648;
    localparam logic [31:0] TOP       = 32'h7FFF_FFFF;
    localparam logic [31:0] BOTTOM    = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [1:0]  st;
    } curve_point_t;

    typedef struct {
        bit           is_cfg;
        logic [2:0]   addr;
        logic [31:0]  data;
        logic         kind;
        logic [3:0]   slot;
        logic [31:0]  x;
        logic [31:0]  y;
        logic [23:0]  prm;
        bit           known;
        curve_point_t want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic        kind = KIND_WRITE;
    logic [3:0]  point_index = '0;
    logic [31:0] point_x = '0;
    logic [31:0] point_y = '0;
    logic [23:0] param = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [1:0]  status;

    curve_point_t expected_points[$];
    plan_row_t    plan[$];
    longint       x_points[TABLE_SLOTS];
    longint       y_points[TABLE_SLOTS];
    logic [15:0]  slots_loaded = '0;
    logic [4:0]   count_reg = '0;
    int           error_count = 0;
    int           idle_cycles = 0;
    int           stall_left = 0;
    bit           calm = 1'b0;

    catmull_rom_spline_eval DUT (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .kind(kind),
        .point_index(point_index),
        .point_x(point_x),
        .point_y(point_y),
        .param(param),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .out_x(out_x),
        .out_y(out_y),
        .status(status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint blend_axis(input bit on_y, input int s, input int cnt,
                                          input longint h00, input longint h10,
                                          input longint h01, input longint h11);
        longint p_lo, p_hi, d0, d1, acc;
        p_lo = on_y ? y_points[s] : x_points[s];
        p_hi = on_y ? y_points[s + 1] : x_points[s + 1];
        d0 = 0;
        d1 = 0;
        if (s > 0)
            d0 = p_hi - (on_y ? y_points[s - 1] : x_points[s - 1]);
        if (s + 2 < cnt)
            d1 = (on_y ? y_points[s + 2] : x_points[s + 2]) - p_lo;
        acc = 2 * (h00 * p_lo + h01 * p_hi) + h10 * d0 + h11 * d1;
        acc = (acc + FRAC_ONE) >>> (FRAC_W + 1);
        if (acc > COORD_MAX)
            return COORD_MAX;
        if (acc < COORD_MIN)
            return COORD_MIN;
        return acc;
    endfunction

    function automatic curve_point_t curve_point_at(input logic [23:0] prm);
        curve_point_t pt;
        int           cnt;
        longint       lim, pos, s, t, t2, t3, h00, h10, h01, h11;
        cnt = (count_reg > TABLE_SLOTS) ? TABLE_SLOTS : int'(count_reg);
        pt = '0;
        if (cnt == 0)
        begin
            pt.st = ST_EMPTY;
        end
        else if (cnt == 1)
        begin
            pt.x = x_points[0][31:0];
            pt.y = y_points[0][31:0];
            pt.st = ST_SINGLE;
        end
        else
        begin
            lim = longint'(cnt - 1) << FRAC_W;
            pos = (longint'(prm) > lim) ? lim : longint'(prm);
            s = pos >> FRAC_W;
            if (s >= cnt - 1)
                s = cnt - 2;
            t = pos - (s << FRAC_W);
            t2 = (t * t + HALF_Q16) >> FRAC_W;
            t3 = (t2 * t + HALF_Q16) >> FRAC_W;
            h00 = 2 * t3 - 3 * t2 + FRAC_ONE;
            h10 = t3 - 2 * t2 + t;
            h01 = 3 * t2 - 2 * t3;
            h11 = t3 - t2;
            pt.x = 32'(blend_axis(1'b0, int'(s), cnt, h00, h10, h01, h11));
            pt.y = 32'(blend_axis(1'b1, int'(s), cnt, h00, h10, h01, h11));
            pt.st = ST_SPLINE;
        end
        return pt;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] coord_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return ($urandom_range(0, 1) != 0) ? TOP : BOTTOM;
        if (r < 30)
            return $urandom();
        return 32'($signed(25'($urandom())));
    endfunction

    function automatic logic [23:0] param_value(input int eff);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10 || eff < 2)
            return 24'($urandom());
        if (r < 22)
            return 24'($urandom_range(0, eff - 1) << FRAC_W);
        return 24'($urandom_range(0, (eff - 1) << FRAC_W));
    endfunction

    function automatic plan_row_t cfg_row(input logic [2:0] addr, input logic [31:0] data);
        plan_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.addr = addr;
        r.data = data;
        return r;
    endfunction

    function automatic plan_row_t wr_row(input logic [3:0] slot, input logic [31:0] x,
                                         input logic [31:0] y);
        plan_row_t r;
        r = '{default: '0};
        r.kind = KIND_WRITE;
        r.slot = slot;
        r.x = x;
        r.y = y;
        r.prm = 24'($urandom());
        return r;
    endfunction

    function automatic plan_row_t ev_row(input logic [23:0] prm);
        plan_row_t r;
        r = '{default: '0};
        r.kind = KIND_EVAL;
        r.slot = 4'($urandom());
        r.x = $urandom();
        r.y = $urandom();
        r.prm = prm;
        return r;
    endfunction

    function automatic plan_row_t ev_known(input logic [23:0] prm, input logic [31:0] x,
                                           input logic [31:0] y, input logic [1:0] st);
        plan_row_t r;
        r = ev_row(prm);
        r.known = 1'b1;
        r.want = '{x: x, y: y, st: st};
        return r;
    endfunction

    task automatic issue_item(input logic k, input logic [3:0] slot, input logic [31:0] x,
                              input logic [31:0] y, input logic [23:0] prm,
                              input bit known, input curve_point_t want);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid  <= 1'b1;
        kind        <= k;
        point_index <= slot;
        point_x     <= x;
        point_y     <= y;
        param       <= prm;
        do @(posedge clk); while (item_stall);
        if (k == KIND_WRITE)
        begin
            x_points[slot] = longint'($signed(x));
            y_points[slot] = longint'($signed(y));
            slots_loaded[slot] = 1'b1;
        end
        else
        begin
            expected_points.push_back(known ? want : curve_point_at(prm));
        end
    endtask

    task automatic drain_points();
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_points.size() > 0)
            @(posedge clk);
    endtask

    task automatic settle_idle();
        drain_points();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_POINT_COUNT)
            count_reg = data[COUNT_W-1:0];
    endtask

    always @(posedge clk)
    begin : result_check
        curve_point_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_points.size() == 0)
            begin
                $display("%0t: unexpected result beat x=%h y=%h status=%0d",
                         $time, out_x, out_y, status);
                error_count++;
            end
            else
            begin
                want = expected_points.pop_front();
                if (out_x !== want.x)
                begin
                    $display("%0t: out_x expected %h, got %h", $time, want.x, out_x);
                    error_count++;
                end
                if (out_y !== want.y)
                begin
                    $display("%0t: out_y expected %h, got %h", $time, want.y, out_y);
                    error_count++;
                end
                if (status !== want.st)
                begin
                    $display("%0t: status expected %0d, got %0d", $time, want.st, status);
                    error_count++;
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
            stall_left = ($urandom_range(0, 2) == 0) ? idle_len() : 0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
            || (psel && penable))
        begin
            idle_cycles = 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, no beat for %0d cycles", $time, idle_cycles);
            $display("tb_top: done, errors");
            $finish;
        end
        else
        begin
            idle_cycles++;
        end
    end

    initial
    begin : stimulus
        plan_row_t   row;
        int          phase, beats, len, eff, slot;
        logic [4:0]  cnt;
        logic [15:0] need;
        bit          want_eval;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        plan.push_back(ev_known(24'h000000, 32'h0, 32'h0, ST_EMPTY));
        plan.push_back(ev_known(24'hFFFFFF, 32'h0, 32'h0, ST_EMPTY));
        plan.push_back(wr_row(4'd0, TOP, BOTTOM));
        plan.push_back(cfg_row(ADDR_POINT_COUNT, 32'd1));
        plan.push_back(ev_known(24'h000000, TOP, BOTTOM, ST_SINGLE));
        plan.push_back(ev_known(24'hFFFFFF, TOP, BOTTOM, ST_SINGLE));
        plan.push_back(cfg_row(ADDR_UNMAPPED, 32'd0));
        plan.push_back(ev_known(24'h5A5A5A, TOP, BOTTOM, ST_SINGLE));
        plan.push_back(wr_row(4'd1, BOTTOM, TOP));
        plan.push_back(cfg_row(ADDR_POINT_COUNT, 32'hFFFF_FFE2));
        plan.push_back(ev_known(24'h000000, TOP, BOTTOM, ST_SPLINE));
        plan.push_back(ev_known(24'h010000, BOTTOM, TOP, ST_SPLINE));
        plan.push_back(ev_known(24'hFFFFFF, BOTTOM, TOP, ST_SPLINE));
        plan.push_back(ev_row(24'h008000));
        plan.push_back(wr_row(4'd0, BOTTOM, TOP));
        plan.push_back(wr_row(4'd1, TOP, BOTTOM));
        plan.push_back(wr_row(4'd2, TOP, BOTTOM));
        plan.push_back(wr_row(4'd3, BOTTOM, TOP));
        plan.push_back(cfg_row(ADDR_POINT_COUNT, 32'd4));
        plan.push_back(ev_row(24'h018000));
        plan.push_back(ev_row(24'h00FFFF));
        plan.push_back(ev_known(24'h030000, BOTTOM, TOP, ST_SPLINE));
        plan.push_back(ev_row(24'h02FFFF));
        plan.push_back(wr_row(4'd2, 32'h0001_2345, 32'hFFFE_DCBA));
        plan.push_back(ev_row(24'h024000));

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.is_cfg)
            begin
                settle_idle();
                write_register(row.addr, row.data);
            end
            else
            begin
                issue_item(row.kind, row.slot, row.x, row.y, row.prm, row.known, row.want);
            end
        end

        // The first phases visit the extreme counts; later ones mostly stay in range.
        phase = 0;
        beats = 0;
        while (beats < RANDOM_BEATS)
        begin
            settle_idle();
            calm = (phase % 4 == 3);
            case (phase)
                0: cnt = 5'd16;
                1: cnt = 5'd31;
                2: cnt = 5'd0;
                3: cnt = 5'd1;
                4: cnt = 5'd2;
                5: cnt = 5'd17;
                default: cnt = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(2, 16))
                                                           : 5'($urandom_range(0, 31));
            endcase
            write_register(ADDR_POINT_COUNT, {27'($urandom()), cnt});
            len = $urandom_range(40, 160);
            for (int n = 0; n < len; n++)
            begin
                if (phase == 2 && n == len / 2)
                    drain_points();
                eff = (count_reg > TABLE_SLOTS) ? TABLE_SLOTS : int'(count_reg);
                need = 16'((32'd1 << eff) - 1);
                want_eval = ($urandom_range(0, 99) < 55);
                if (want_eval && (slots_loaded & need) == need)
                begin
                    issue_item(KIND_EVAL, 4'($urandom()), $urandom(), $urandom(),
                               param_value(eff), 1'b0, '0);
                end
                else
                begin
                    slot = $urandom_range(0, TABLE_SLOTS - 1);
                    if (want_eval)
                    begin
                        for (int i = TABLE_SLOTS - 1; i >= 0; i--)
                            if (need[i] && !slots_loaded[i])
                                slot = i;
                    end
                    issue_item(KIND_WRITE, 4'(slot), coord_value(), coord_value(),
                               24'($urandom()), 1'b0, '0);
                end
                beats++;
            end
            phase++;
        end

        calm = 1'b0;
        settle_idle();
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
